/* rtl/core/hpq_pkg.sv */
// hpq_pkg: shared types and constants of the indexed min-heap queue
// holds the command and status bundles between controller and datapath
// no dependencies
package hpq_pkg;

    // fixed widths of the port fields
    localparam int OP_W      = 2;
    localparam int IN_ID_W   = 8;
    localparam int IN_KEY_W  = 32;
    localparam int OUT_ID_W  = 8;
    localparam int OUT_KEY_W = 32;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 9;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // heap read address select
    localparam logic [2:0] HR_ROOT   = 3'd0;
    localparam logic [2:0] HR_POS    = 3'd1;
    localparam logic [2:0] HR_PARENT = 3'd2;
    localparam logic [2:0] HR_LEFT   = 3'd3;
    localparam logic [2:0] HR_RIGHT  = 3'd4;
    localparam logic [2:0] HR_LAST   = 3'd5;

    // heap write select
    localparam logic [1:0] HW_NONE   = 2'd0;
    localparam logic [1:0] HW_PARENT = 2'd1;
    localparam logic [1:0] HW_BEST   = 2'd2;
    localparam logic [1:0] HW_CUR    = 2'd3;

    typedef struct packed {
        logic                accept;
        logic [2:0]          hrd;
        logic [1:0]          hwr;
        logic                clr_wr;
        logic                pos_from_q;
        logic                pos_insert;
        logic                pos_parent;
        logic                pos_best;
        logic                pos_root;
        logic                cur_from_q;
        logic                cnt_dec;
        logic                cnt_zero;
        logic                best_left;
        logic                best_right;
        logic                ld_top;
        logic                st_ld;
        logic [STATUS_W-1:0] st_code;
        logic                fin;
    } cmd_t;

    typedef struct packed {
        logic present;
        logic full;
        logic empty;
        logic single;
        logic at_root;
        logic less_parent;
        logic left_ok;
        logic right_ok;
        logic moved;
        logic out_free;
        logic clr_last;
    } stat_t;

endpackage

/* rtl/core/indexed_min_heap_priority_queue_top.sv */
// indexed min-heap queue: one word out per word in, one operation at a time; push, pop and
// key update walk the heap level by level through the single read port of the heap memory,
// and a stalled result delays the finish; the next word is taken while the last result waits;
// after reset a sweep clears every entry of the position memory with in_stall high
// depends on hpq_pkg, hpq_ctrl, hpq_dp
module indexed_min_heap_priority_queue_top #(
    parameter int HEAP_DEPTH = 256,
    parameter int ID_COUNT   = 256,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hpq_pkg::OP_W-1:0]       op,
    input  logic [hpq_pkg::IN_ID_W-1:0]    elem_id,
    input  logic [hpq_pkg::IN_KEY_W-1:0]   key,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hpq_pkg::OUT_ID_W-1:0]   out_id,
    output logic [hpq_pkg::OUT_KEY_W-1:0]  out_key,
    output logic [hpq_pkg::STATUS_W-1:0]   status,
    output logic [hpq_pkg::COUNT_W-1:0]    count
);

    hpq_pkg::cmd_t  cmd;
    hpq_pkg::stat_t stat;

    // sequencer
    hpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .stat     (stat),
        .cmd      (cmd)
    );

    // heap storage and arithmetic
    hpq_dp #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .ID_COUNT   (ID_COUNT),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .elem_id   (elem_id),
        .key       (key),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_id    (out_id),
        .out_key   (out_key),
        .status    (status),
        .count     (count)
    );

endmodule

/* rtl/core/hpq_dp.sv */
// hpq_dp: datapath of the indexed min-heap queue
// heap memory, position memory, carried entry, counters and output word
// depends on hpq_pkg
module hpq_dp #(
    parameter int HEAP_DEPTH = 256,
    parameter int ID_COUNT   = 256,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hpq_pkg::cmd_t                  cmd,
    output hpq_pkg::stat_t                 stat,
    input  logic [hpq_pkg::IN_ID_W-1:0]    elem_id,
    input  logic [hpq_pkg::IN_KEY_W-1:0]   key,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [hpq_pkg::OUT_ID_W-1:0]   out_id,
    output logic [hpq_pkg::OUT_KEY_W-1:0]  out_key,
    output logic [hpq_pkg::STATUS_W-1:0]   status,
    output logic [hpq_pkg::COUNT_W-1:0]    count
);

    localparam int ID_W   = $clog2(ID_COUNT);
    localparam int SLOT_W = $clog2(HEAP_DEPTH + 1);

    // memories
    logic [ID_W-1:0]      heap_id_mem  [HEAP_DEPTH+1];
    logic [KEY_WIDTH-1:0] heap_key_mem [HEAP_DEPTH+1];
    logic [SLOT_W-1:0]    pos_mem      [ID_COUNT];

    logic [ID_W-1:0]      hq_id_reg;
    logic [KEY_WIDTH-1:0] hq_key_reg;
    logic [SLOT_W-1:0]    pq_reg;

    logic [SLOT_W-1:0]    count_reg;
    logic [SLOT_W-1:0]    pos_reg;
    logic [ID_W-1:0]      cur_id_reg;
    logic [KEY_WIDTH-1:0] cur_key_reg;
    logic [ID_W-1:0]      best_id_reg;
    logic [KEY_WIDTH-1:0] best_key_reg;
    logic [SLOT_W-1:0]    best_slot_reg;
    logic [ID_W-1:0]      clr_reg;

    logic [hpq_pkg::OUT_ID_W-1:0]  res_id_reg;
    logic [hpq_pkg::OUT_KEY_W-1:0] res_key_reg;
    logic [hpq_pkg::STATUS_W-1:0]  res_st_reg;

    logic                          out_valid_reg;
    logic [hpq_pkg::OUT_ID_W-1:0]  out_id_reg;
    logic [hpq_pkg::OUT_KEY_W-1:0] out_key_reg;
    logic [hpq_pkg::STATUS_W-1:0]  out_st_reg;
    logic [hpq_pkg::COUNT_W-1:0]   out_cnt_reg;

    logic [ID_W-1:0]      in_id;
    logic [KEY_WIDTH-1:0] in_key;
    logic [SLOT_W:0]      left_slot;
    logic [SLOT_W:0]      right_slot;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 left_less;

    // input word reduced to table and key widths
    assign in_id  = ID_W'(elem_id % ID_COUNT);
    assign in_key = KEY_WIDTH'(key);

    assign left_slot  = {pos_reg, 1'b0};
    assign right_slot = {pos_reg, 1'b1};
    assign left_less  = hq_key_reg < cur_key_reg;

    // heap read address
    always_comb
    begin
        case (cmd.hrd)
            hpq_pkg::HR_ROOT:   rd_addr = SLOT_W'(1);
            hpq_pkg::HR_POS:    rd_addr = pq_reg;
            hpq_pkg::HR_PARENT: rd_addr = pos_reg >> 1;
            hpq_pkg::HR_LEFT:   rd_addr = left_slot[SLOT_W-1:0];
            hpq_pkg::HR_RIGHT:  rd_addr = right_slot[SLOT_W-1:0];
            hpq_pkg::HR_LAST:   rd_addr = count_reg;
            default:            rd_addr = SLOT_W'(1);
        endcase
    end

    // heap memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        hq_id_reg  <= heap_id_mem[rd_addr];
        hq_key_reg <= heap_key_mem[rd_addr];
        case (cmd.hwr)
            hpq_pkg::HW_PARENT:
            begin
                heap_id_mem[pos_reg]  <= hq_id_reg;
                heap_key_mem[pos_reg] <= hq_key_reg;
            end
            hpq_pkg::HW_BEST:
            begin
                heap_id_mem[pos_reg]  <= best_id_reg;
                heap_key_mem[pos_reg] <= best_key_reg;
            end
            hpq_pkg::HW_CUR:
            begin
                heap_id_mem[pos_reg]  <= cur_id_reg;
                heap_key_mem[pos_reg] <= cur_key_reg;
            end
            default: ;
        endcase
    end

    // position memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        pq_reg <= pos_mem[in_id];
        if (cmd.clr_wr)
        begin
            pos_mem[clr_reg] <= '0;
        end
        else
        begin
            case (cmd.hwr)
                hpq_pkg::HW_PARENT: pos_mem[hq_id_reg]   <= pos_reg;
                hpq_pkg::HW_BEST:   pos_mem[best_id_reg] <= pos_reg;
                hpq_pkg::HW_CUR:    pos_mem[cur_id_reg]  <= pos_reg;
                default: ;
            endcase
        end
    end

    // control registers: count, clearing sweep, output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + ID_W'(1);
            end
            if (cmd.cnt_zero)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - SLOT_W'(1);
            end
            else if (cmd.pos_insert)
            begin
                count_reg <= count_reg + SLOT_W'(1);
            end
            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // carried entry, position, best child, result and output word registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_id_reg  <= in_id;
            cur_key_reg <= in_key;
            res_id_reg  <= '0;
            res_key_reg <= '0;
        end
        else if (cmd.cur_from_q)
        begin
            cur_id_reg  <= hq_id_reg;
            cur_key_reg <= hq_key_reg;
        end

        if (cmd.pos_from_q)
        begin
            pos_reg <= pq_reg;
        end
        else if (cmd.pos_insert)
        begin
            pos_reg <= count_reg + SLOT_W'(1);
        end
        else if (cmd.pos_parent)
        begin
            pos_reg <= pos_reg >> 1;
        end
        else if (cmd.pos_best)
        begin
            pos_reg <= best_slot_reg;
        end
        else if (cmd.pos_root)
        begin
            pos_reg <= SLOT_W'(1);
        end

        if (cmd.best_left)
        begin
            if (left_less)
            begin
                best_id_reg   <= hq_id_reg;
                best_key_reg  <= hq_key_reg;
                best_slot_reg <= left_slot[SLOT_W-1:0];
            end
            else
            begin
                best_id_reg   <= cur_id_reg;
                best_key_reg  <= cur_key_reg;
                best_slot_reg <= pos_reg;
            end
        end
        else if (cmd.best_right && (hq_key_reg < best_key_reg))
        begin
            best_id_reg   <= hq_id_reg;
            best_key_reg  <= hq_key_reg;
            best_slot_reg <= right_slot[SLOT_W-1:0];
        end

        if (cmd.ld_top)
        begin
            res_id_reg  <= hpq_pkg::OUT_ID_W'(hq_id_reg);
            res_key_reg <= hpq_pkg::OUT_KEY_W'(hq_key_reg);
        end
        if (cmd.st_ld)
        begin
            res_st_reg <= cmd.st_code;
        end

        if (cmd.fin)
        begin
            out_id_reg  <= res_id_reg;
            out_key_reg <= res_key_reg;
            out_st_reg  <= res_st_reg;
            out_cnt_reg <= hpq_pkg::COUNT_W'(count_reg);
        end
    end

    // status to the controller
    always_comb
    begin
        stat.present     = (pos_reg != '0) && (pos_reg <= count_reg)
                           && (hq_id_reg == cur_id_reg);
        stat.full        = count_reg == SLOT_W'(HEAP_DEPTH);
        stat.empty       = count_reg == '0;
        stat.single      = count_reg == SLOT_W'(1);
        stat.at_root     = pos_reg == SLOT_W'(1);
        stat.less_parent = cur_key_reg < hq_key_reg;
        stat.left_ok     = left_slot <= {1'b0, count_reg};
        stat.right_ok    = right_slot <= {1'b0, count_reg};
        stat.moved       = best_slot_reg != pos_reg;
        stat.out_free    = !out_valid_reg || !out_stall;
        stat.clr_last    = clr_reg == ID_W'(ID_COUNT - 1);
    end

    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_key   = out_key_reg;
    assign status    = out_st_reg;
    assign count     = out_cnt_reg;

endmodule

/* rtl/core/hpq_ctrl.sv */
// hpq_ctrl: sequencer of the indexed min-heap queue
// walks lookup, sift-up and sift-down steps and drives datapath commands
// depends on hpq_pkg
module hpq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [hpq_pkg::OP_W-1:0]    op,
    input  hpq_pkg::stat_t              stat,
    output hpq_pkg::cmd_t               cmd
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PLOOK  = 4'd2;
    localparam logic [3:0] S_PCHK   = 4'd3;
    localparam logic [3:0] S_UP_RD  = 4'd4;
    localparam logic [3:0] S_UP_CMP = 4'd5;
    localparam logic [3:0] S_DN_RD  = 4'd6;
    localparam logic [3:0] S_DN_L   = 4'd7;
    localparam logic [3:0] S_DN_R   = 4'd8;
    localparam logic [3:0] S_DN_MV  = 4'd9;
    localparam logic [3:0] S_WR_CUR = 4'd10;
    localparam logic [3:0] S_POP1   = 4'd11;
    localparam logic [3:0] S_POP2   = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       down_reg;
    logic       down_next;

    assign in_stall = state_reg != S_IDLE;

    // state and sift-down flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            down_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            down_reg  <= down_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        cmd.hrd    = hpq_pkg::HR_ROOT;
        cmd.hwr    = hpq_pkg::HW_NONE;
        state_next = state_reg;
        down_next  = down_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (op[1])
                    begin
                        cmd.cnt_zero = 1'b1;
                        cmd.st_ld    = 1'b1;
                        cmd.st_code  = hpq_pkg::ST_INSERTED;
                        state_next   = S_FIN;
                    end
                    else if (op == hpq_pkg::OP_POP)
                    begin
                        cmd.st_ld = 1'b1;
                        if (stat.empty)
                        begin
                            cmd.st_code = hpq_pkg::ST_EMPTY;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            cmd.st_code = hpq_pkg::ST_POPPED;
                            cmd.hrd     = hpq_pkg::HR_ROOT;
                            state_next  = S_POP1;
                        end
                    end
                    else
                    begin
                        state_next = S_PLOOK;
                    end
                end
            end
            S_PLOOK:
            begin
                cmd.pos_from_q = 1'b1;
                cmd.hrd        = hpq_pkg::HR_POS;
                state_next     = S_PCHK;
            end
            S_PCHK:
            begin
                cmd.st_ld = 1'b1;
                if (stat.present)
                begin
                    cmd.st_code = hpq_pkg::ST_UPDATED;
                    down_next   = 1'b1;
                    state_next  = S_UP_RD;
                end
                else if (stat.full)
                begin
                    cmd.st_code = hpq_pkg::ST_FULL;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.st_code    = hpq_pkg::ST_INSERTED;
                    cmd.pos_insert = 1'b1;
                    down_next      = 1'b0;
                    state_next     = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                if (stat.at_root)
                begin
                    state_next = down_reg ? S_DN_RD : S_WR_CUR;
                end
                else
                begin
                    cmd.hrd    = hpq_pkg::HR_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.less_parent)
                begin
                    cmd.hwr        = hpq_pkg::HW_PARENT;
                    cmd.pos_parent = 1'b1;
                    state_next     = S_UP_RD;
                end
                else
                begin
                    state_next = down_reg ? S_DN_RD : S_WR_CUR;
                end
            end
            S_DN_RD:
            begin
                if (stat.left_ok)
                begin
                    cmd.hrd    = hpq_pkg::HR_LEFT;
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_WR_CUR;
                end
            end
            S_DN_L:
            begin
                cmd.best_left = 1'b1;
                if (stat.right_ok)
                begin
                    cmd.hrd    = hpq_pkg::HR_RIGHT;
                    state_next = S_DN_R;
                end
                else
                begin
                    state_next = S_DN_MV;
                end
            end
            S_DN_R:
            begin
                cmd.best_right = 1'b1;
                state_next     = S_DN_MV;
            end
            S_DN_MV:
            begin
                if (stat.moved)
                begin
                    cmd.hwr      = hpq_pkg::HW_BEST;
                    cmd.pos_best = 1'b1;
                    state_next   = S_DN_RD;
                end
                else
                begin
                    state_next = S_WR_CUR;
                end
            end
            S_WR_CUR:
            begin
                cmd.hwr    = hpq_pkg::HW_CUR;
                state_next = S_FIN;
            end
            S_POP1:
            begin
                cmd.ld_top = 1'b1;
                if (stat.single)
                begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.hrd    = hpq_pkg::HR_LAST;
                    state_next = S_POP2;
                end
            end
            S_POP2:
            begin
                cmd.cur_from_q = 1'b1;
                cmd.cnt_dec    = 1'b1;
                cmd.pos_root   = 1'b1;
                state_next     = S_DN_RD;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
